FILE: rtl/rrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrr_pkg: shared types and constants of the round-robin ready ring
// Slot count, field widths, request kinds and the request/result records.
// ----------------------------------------------------------------------------
package rrr_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
	localparam int KIND_W    = 2;
	localparam int SLOT_W    = 4;
	localparam int LEN_W     = 5;

	localparam logic [KIND_W-1:0] KIND_ADMIT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NEXT   = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] thread_slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] chosen_slot;
		logic              chosen_valid;
		logic [LEN_W-1:0]  queue_length;
		logic              status;
	} rsp_t;

endpackage

FILE: rtl/rrr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrr_req_if: request channel
// Valid/ready handshake carrying a request kind and a thread slot.
// ----------------------------------------------------------------------------
interface rrr_req_if;
	logic                         valid;
	logic                         ready;
	logic [rrr_pkg::KIND_W-1:0]   kind;
	logic [rrr_pkg::SLOT_W-1:0]   thread_slot;

	modport source (output valid, output kind, output thread_slot, input ready);
	modport sink (input valid, input kind, input thread_slot, output ready);
endinterface

FILE: rtl/rrr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrr_rsp_if: result channel
// Valid/ready handshake carrying the chosen slot, ring length and status.
// ----------------------------------------------------------------------------
interface rrr_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rrr_pkg::SLOT_W-1:0]  chosen_slot;
	logic                        chosen_valid;
	logic [rrr_pkg::LEN_W-1:0]   queue_length;
	logic                        status;

	modport source (output valid, output chosen_slot, output chosen_valid,
		output queue_length, output status, input ready);
	modport sink (input valid, input chosen_slot, input chosen_valid,
		input queue_length, input status, output ready);
endinterface

FILE: rtl/rrr_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrr_ring: ring state and its update logic
// Holds the forward/backward link flops, membership, head, tail and count,
// and applies one request per step.
// ----------------------------------------------------------------------------
module rrr_ring (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  rrr_pkg::req_t req,
	output rrr_pkg::rsp_t rsp
);
	import rrr_pkg::*;

	typedef struct packed {
		logic en;
		idx_t addr;
		idx_t data;
	} link_wr_t;

	idx_t                 fwd_q [MAX_SLOTS];
	idx_t                 bwd_q [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] member_q;
	idx_t                 head_q;
	idx_t                 tail_q;
	cnt_t                 count_q;

	idx_t                 s;
	logic                 in_range;
	logic                 is_member;
	idx_t                 fwd_rd_addr;
	idx_t                 fwd_rd;
	idx_t                 bwd_rd;
	link_wr_t             fwd_a, fwd_b, bwd_a, bwd_b;
	logic [MAX_SLOTS-1:0] member_d;
	idx_t                 head_d;
	idx_t                 tail_d;
	cnt_t                 count_d;

	assign s           = idx_t'(req.thread_slot);
	assign in_range    = (32'(req.thread_slot) < 32'(MAX_SLOTS));
	assign is_member   = member_q[s];
	assign fwd_rd_addr = (req.kind == KIND_NEXT) ? head_q : s;
	assign fwd_rd      = fwd_q[fwd_rd_addr];
	assign bwd_rd      = bwd_q[s];

	always_comb begin
		fwd_a    = '0;
		fwd_b    = '0;
		bwd_a    = '0;
		bwd_b    = '0;
		member_d = member_q;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		rsp      = '0;
		unique case (req.kind)
			KIND_ADMIT: begin
				if (in_range && !is_member) begin
					member_d[s] = 1'b1;
					count_d     = count_q + cnt_t'(1);
					tail_d      = s;
					fwd_a       = '{en: 1'b1, addr: s, data: s};
					bwd_a       = '{en: 1'b1, addr: s, data: s};
					if (count_q == '0) begin
						head_d = s;
					end else begin
						fwd_a.data = head_q;
						bwd_a.data = tail_q;
						fwd_b      = '{en: 1'b1, addr: tail_q, data: s};
						bwd_b      = '{en: 1'b1, addr: head_q, data: s};
					end
				end else begin
					rsp.status = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (in_range && is_member) begin
					member_d[s] = 1'b0;
					count_d     = count_q - cnt_t'(1);
					if (count_q <= cnt_t'(1)) begin
						head_d = '0;
					end else begin
						fwd_a = '{en: 1'b1, addr: bwd_rd, data: fwd_rd};
						bwd_a = '{en: 1'b1, addr: fwd_rd, data: bwd_rd};
						if (head_q == s) head_d = fwd_rd;
						if (tail_q == s) tail_d = bwd_rd;
					end
				end else begin
					rsp.status = 1'b1;
				end
			end
			KIND_NEXT: begin
				if (count_q != '0) begin
					rsp.chosen_slot  = SLOT_W'(head_q);
					rsp.chosen_valid = 1'b1;
					head_d           = fwd_rd;
					tail_d           = head_q;
				end
			end
			default: begin
				rsp.status = 1'b1;
			end
		endcase
		rsp.queue_length = LEN_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_q <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
		end else if (step) begin
			member_q <= member_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				if (fwd_a.en && fwd_a.addr == idx_t'(i)) begin
					fwd_q[i] <= fwd_a.data;
				end else if (fwd_b.en && fwd_b.addr == idx_t'(i)) begin
					fwd_q[i] <= fwd_b.data;
				end
				if (bwd_a.en && bwd_a.addr == idx_t'(i)) begin
					bwd_q[i] <= bwd_a.data;
				end else if (bwd_b.en && bwd_b.addr == idx_t'(i)) begin
					bwd_q[i] <= bwd_b.data;
				end
			end
		end
	end

endmodule

FILE: rtl/round_robin_ready_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_ready_ring: round-robin ready queue of thread slots
// Admit, remove and next/rotate requests on a circular doubly linked ring.
// ----------------------------------------------------------------------------
// One request per clock is accepted while the result channel is not stalled,
// and each yields one result (input register, then result register). The link
// tables live in flops, so admit, remove and rotate each finish between the
// two registers, and a request sees all earlier updates. Duplicate admit,
// absent remove and unused kinds are rejected with status 1 and no change.
module round_robin_ready_ring (
	input logic  clk,
	input logic  arst_n,
	rrr_req_if.sink   req,
	rrr_rsp_if.source rsp
);
	import rrr_pkg::*;

	logic  req_valid_s1;
	req_t  req_s1;
	logic  rsp_valid_s2;
	rsp_t  rsp_s2;
	rsp_t  ring_rsp;
	logic  advance;
	logic  fire;

	assign advance   = !rsp_valid_s2 || rsp.ready;
	assign fire      = req_valid_s1 && advance;
	assign req.ready = !req_valid_s1 || advance;

	rrr_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire),
		.req    (req_s1),
		.rsp    (ring_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_s2 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				req_valid_s1 <= 1'b1;
			end else if (fire) begin
				req_valid_s1 <= 1'b0;
			end
			if (fire) begin
				rsp_valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.kind        <= req.kind;
			req_s1.thread_slot <= req.thread_slot;
		end
		if (fire) begin
			rsp_s2 <= ring_rsp;
		end
	end

	assign rsp.valid        = rsp_valid_s2;
	assign rsp.chosen_slot  = rsp_s2.chosen_slot;
	assign rsp.chosen_valid = rsp_s2.chosen_valid;
	assign rsp.queue_length = rsp_s2.queue_length;
	assign rsp.status       = rsp_s2.status;

	a_chosen_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_s2 && rsp_s2.chosen_valid |->
			!rsp_s2.status && rsp_s2.queue_length != '0)
		else $error("chosen result with error or empty ring");

	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_s2)
		else $error("processed request left no result");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> req_valid_s1 && rsp_valid_s2 && !rsp.ready)
		else $error("request side stalled without a blocked result");

endmodule

FILE: bench/round_robin_ready_ring_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_ready_ring_tb: self-checking bench for the ready ring
// Drives admit, remove, next and unused requests with random gaps on both channels.
// A local copy of the linked ring predicts every result, and the results
// are compared in order against that prediction.
// ----------------------------------------------------------------------------
module round_robin_ready_ring_tb;
	import rrr_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;

	rrr_req_if req_ch ();
	rrr_rsp_if rsp_ch ();

	round_robin_ready_ring u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// ring copy used for prediction
	idx_t        fwd_slot [MAX_SLOTS];
	idx_t        bwd_slot [MAX_SLOTS];
	bit          in_ring  [MAX_SLOTS];
	idx_t        head_slot = '0;
	int unsigned ring_size = 0;

	rsp_t        pending_results [$];
	int          error_count = 0;
	int unsigned cycle_count = 0;
	bit          no_gaps = 1'b0;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic rsp_t ring_step(req_t r);
		rsp_t e;
		idx_t s;
		idx_t p;
		idx_t n;
		e = '0;
		s = idx_t'(r.thread_slot);
		case (r.kind)
		KIND_ADMIT: begin
			if (r.thread_slot >= MAX_SLOTS || in_ring[s]) begin
				e.status = 1'b1;
			end else begin
				if (ring_size == 0) begin
					fwd_slot[s] = s;
					bwd_slot[s] = s;
					head_slot   = s;
				end else begin
					p = bwd_slot[head_slot];
					fwd_slot[s] = head_slot;
					bwd_slot[s] = p;
					fwd_slot[p] = s;
					bwd_slot[head_slot] = s;
				end
				in_ring[s] = 1'b1;
				ring_size++;
			end
		end
		KIND_REMOVE: begin
			if (r.thread_slot >= MAX_SLOTS || !in_ring[s]) begin
				e.status = 1'b1;
			end else begin
				if (ring_size <= 1) begin
					head_slot = '0;
				end else begin
					p = bwd_slot[s];
					n = fwd_slot[s];
					fwd_slot[p] = n;
					bwd_slot[n] = p;
					if (head_slot == s)
						head_slot = n;
				end
				in_ring[s] = 1'b0;
				ring_size--;
			end
		end
		KIND_NEXT: begin
			if (ring_size != 0) begin
				e.chosen_slot  = head_slot;
				e.chosen_valid = 1'b1;
				head_slot      = fwd_slot[head_slot];
			end
		end
		default: begin
			e.status = 1'b1;
		end
		endcase
		e.queue_length = LEN_W'(ring_size);
		return e;
	endfunction

	function automatic logic [SLOT_W-1:0] pick_slot(bit member);
		idx_t cand [$];
		for (int i = 0; i < MAX_SLOTS; i++)
			if (in_ring[i] == member)
				cand.push_back(idx_t'(i));
		if (cand.size() == 0)
			return SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	function automatic void check_field(string name, logic [LEN_W-1:0] want,
		logic [LEN_W-1:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	task automatic send_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot);
		int   gap;
		req_t r;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap != 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid       = 1'b1;
		req_ch.kind        = kind;
		req_ch.thread_slot = slot;
		do @(posedge clk); while (!req_ch.ready);
		r.kind        = kind;
		r.thread_slot = slot;
		pending_results.push_back(ring_step(r));
	endtask

	task automatic wait_until_drained();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_empty_ring();
		send_request(KIND_NEXT, 4'd9);
		send_request(KIND_REMOVE, 4'd3);
		send_request(KIND_UNUSED, 4'd15);
	endtask

	task automatic test_link_updates();
		send_request(KIND_ADMIT, 4'd0);
		send_request(KIND_ADMIT, 4'd15);
		send_request(KIND_ADMIT, 4'd7);
		send_request(KIND_ADMIT, 4'd15);
		send_request(KIND_NEXT, 4'd0);
		send_request(KIND_REMOVE, 4'd7);
		send_request(KIND_REMOVE, 4'd15);
		send_request(KIND_REMOVE, 4'd0);
	endtask

	task automatic test_full_ring();
		int order [MAX_SLOTS];
		for (int i = 0; i < MAX_SLOTS; i++)
			order[i] = i;
		order.shuffle();
		for (int i = 0; i < MAX_SLOTS; i++)
			send_request(KIND_ADMIT, SLOT_W'(order[i]));
	endtask

	// mostly legal requests, plus some random noise
	task automatic test_mixed_traffic(int count, int admit_weight);
		int roll;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < 10)
				send_request(KIND_W'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 15)));
			else if (roll < 10 + admit_weight)
				send_request(KIND_ADMIT, pick_slot(1'b0));
			else if (roll < 35 + admit_weight)
				send_request(KIND_NEXT, SLOT_W'($urandom_range(0, 15)));
			else
				send_request(KIND_REMOVE, pick_slot(1'b1));
		end
	endtask

	initial begin : result_sink
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_gaps ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: result with no request pending, actual slot %0d len %0d",
					$time, rsp_ch.chosen_slot, rsp_ch.queue_length);
			end else begin
				want = pending_results.pop_front();
				check_field("chosen_slot", LEN_W'(want.chosen_slot),
					LEN_W'(rsp_ch.chosen_slot));
				check_field("chosen_valid", LEN_W'(want.chosen_valid),
					LEN_W'(rsp_ch.chosen_valid));
				check_field("queue_length", want.queue_length, rsp_ch.queue_length);
				check_field("status", LEN_W'(want.status), LEN_W'(rsp_ch.status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MAX_SLOTS; i++)
			in_ring[i] = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.kind        = KIND_ADMIT;
		req_ch.thread_slot = '0;
		arst_n             = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_ring();
		test_link_updates();
		test_full_ring();
		test_mixed_traffic(150, 15);
		test_mixed_traffic(200, 55);
		wait_until_drained();
		no_gaps = 1'b1;
		test_mixed_traffic(100, 40);
		no_gaps = 1'b0;
		test_mixed_traffic(150, 15);
		test_mixed_traffic(100, 55);
		wait_until_drained();

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/rrr_pkg.sv
rtl/rrr_req_if.sv
rtl/rrr_rsp_if.sv
rtl/rrr_ring.sv
rtl/round_robin_ready_ring.sv
bench/round_robin_ready_ring_tb.sv
